[src/scd_pkg.sv]
// Shared types and constants of the system-call trap dispatcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scd_pkg;

  localparam int PATCH_SLOTS   = 64;
  localparam int PENDING_SLOTS = 32;
  localparam int MAP_ENTRIES   = 3072;

  localparam int PATCH_W  = $clog2(PATCH_SLOTS);
  localparam int PCOUNT_W = $clog2(PATCH_SLOTS + 1);
  localparam int SLOT_W   = $clog2(PENDING_SLOTS);
  localparam int PCNT_W   = $clog2(PENDING_SLOTS + 1);
  localparam int KEY_W    = $clog2(MAP_ENTRIES);
  localparam int MAP_W    = 7;

  localparam logic [MAP_W-1:0] MAP_EMPTY = '1;

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_LDR  = 2'd1,
    K_LDPC = 2'd2,
    K_EXEC = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RES_NONE = 3'd0,
    RES_HEAD = 3'd1,
    RES_TAIL = 3'd2,
    RES_DROP = 3'd3,
    RES_FULL = 3'd4
  } res_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP_RD,
    S_ADD_DEC,
    S_PC_MAP,
    S_PC_HOOK,
    S_PC_DROP,
    S_SCAN,
    S_CMP,
    S_RM,
    S_MOVE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0]        ret;
    logic [31:0]        stack;
    logic [PATCH_W-1:0] patch;
  } pend_t;

  typedef struct packed {
    logic [31:0] number;
    logic [1:0]  hooks;
  } patch_t;

  typedef struct packed {
    res_code_t          code;
    logic [PATCH_W-1:0] idx;
    logic [31:0]        num;
    logic [SLOT_W-1:0]  slot;
  } res_t;

endpackage
`default_nettype wire

[src/syscall_trap_dispatcher_top.sv]
// Load-r12 and rejected requests go straight to the final state; pre-execute requests
// scan the pending slots one at a time, removing each matching entry.
// Throughput: one request at a time; the next is taken once the last result is queued.
// Reset: synchronous; a clearing pass over all 3072 entries fills the key map with empty
// marks, in_ready stays low until it ends.
// Uses scd_pkg and scd_ram.
`timescale 1ns / 1ps
`default_nettype none
module syscall_trap_dispatcher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic signed [12:0] offset,
  input  wire logic [31:0] syscall_number,
  input  wire logic        has_head,
  input  wire logic        has_tail,
  input  wire logic [31:0] stack_pointer,
  input  wire logic [31:0] link_register,
  input  wire logic [31:0] program_counter,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_res,
  output logic [5:0]       patch_index,
  output logic [31:0]      syscall_id,
  output logic [4:0]       pending_slot,
  output logic             last
);

  scd_pkg::state_t state, state_next;

  logic [1:0]  kind_q;
  logic [31:0] sys_q, sp_q, lr_q, pc_q;
  logic        head_q, tail_q;
  logic [scd_pkg::KEY_W-1:0]    mkey, mkey_next;
  logic [3:0]  tsel;
  logic [1:0]  cdown;
  logic [scd_pkg::PCOUNT_W-1:0] pcount;
  logic [scd_pkg::PCNT_W-1:0]   pend_cnt;
  logic [scd_pkg::PCNT_W-1:0]   ptr;
  logic [scd_pkg::PATCH_W-1:0]  pidx, pidx_next;
  logic [scd_pkg::KEY_W-1:0]    clr;
  logic        hvalid;
  scd_pkg::res_t held;

  logic                         map_we;
  logic [scd_pkg::KEY_W-1:0]    map_waddr;
  logic [scd_pkg::MAP_W-1:0]    map_wdata, map_rdata;
  logic                         patch_we;
  logic [scd_pkg::PATCH_W-1:0]  patch_waddr, patch_raddr;
  scd_pkg::patch_t              patch_wdata, patch_rdata;
  logic                         pend_we;
  logic [scd_pkg::SLOT_W-1:0]   pend_waddr, pend_raddr;
  scd_pkg::pend_t               pend_wdata, pend_rdata;

  logic          emit_req, emit_ok, emit_go, fin_go;
  scd_pkg::res_t emit_val;
  logic          out_free, accept;
  logic          add_key_ok, pc_ok, arm_ok;
  logic [12:0]   negoff;
  logic [1:0]    tbl;
  logic          pcount_inc, pend_inc, pend_dec, ptr_inc;
  logic [scd_pkg::SLOT_W-1:0]   last_slot;
  logic          rec, drop;

  assign out_free   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign negoff     = 13'd0 - offset;
  assign arm_ok     = offset == -13'sd4 || offset == -13'sd8 || offset == -13'sd12;
  assign tbl        = tsel[3:2];
  assign add_key_ok = syscall_number[31:16] == 16'd0 && syscall_number[15:14] != 2'd0;
  assign pc_ok      = cdown == 2'd1 && !offset[12] && offset[1:0] == 2'd0 && tbl != 2'd0;
  assign last_slot  = scd_pkg::SLOT_W'(pend_cnt - scd_pkg::PCNT_W'(1));
  assign rec        = patch_rdata.hooks[1] &&
                      pend_cnt < scd_pkg::PCNT_W'(scd_pkg::PENDING_SLOTS);
  assign drop       = patch_rdata.hooks[1] && !rec;
  assign emit_ok    = !hvalid || out_free;
  assign emit_go    = emit_req && emit_ok;

  always_comb begin
    if (scd_pkg::kind_t'(kind) == scd_pkg::K_ADD) begin
      mkey_next = {syscall_number[15:14] - 2'd1, syscall_number[11:2]};
    end else begin
      mkey_next = {tbl - 2'd1, offset[11:2]};
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    map_we      = 1'b0;
    map_waddr   = mkey;
    map_wdata   = scd_pkg::MAP_W'(pcount);
    patch_we    = 1'b0;
    patch_waddr = pcount[scd_pkg::PATCH_W-1:0];
    patch_wdata = '{number: sys_q, hooks: {tail_q, head_q}};
    patch_raddr = pidx;
    pidx_next   = pidx;
    pend_we     = 1'b0;
    pend_waddr  = pend_cnt[scd_pkg::SLOT_W-1:0];
    pend_wdata  = '{ret: {lr_q[31:1], 1'b0}, stack: sp_q, patch: pidx};
    pend_raddr  = ptr[scd_pkg::SLOT_W-1:0];
    emit_req    = 1'b0;
    emit_val    = '{code: scd_pkg::RES_NONE, idx: '0, num: '0, slot: '0};
    fin_go      = 1'b0;
    pcount_inc  = 1'b0;
    pend_inc    = 1'b0;
    pend_dec    = 1'b0;
    ptr_inc     = 1'b0;
    case (state)
      scd_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        map_wdata = scd_pkg::MAP_EMPTY;
        if (clr == scd_pkg::KEY_W'(scd_pkg::MAP_ENTRIES - 1)) begin
          state_next = scd_pkg::S_IDLE;
        end
      end
      scd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (scd_pkg::kind_t'(kind))
            scd_pkg::K_ADD:  state_next = add_key_ok ? scd_pkg::S_MAP_RD : scd_pkg::S_FIN;
            scd_pkg::K_LDPC: state_next = pc_ok ? scd_pkg::S_MAP_RD : scd_pkg::S_FIN;
            scd_pkg::K_EXEC: state_next = scd_pkg::S_SCAN;
            default:         state_next = scd_pkg::S_FIN;
          endcase
        end
      end
      scd_pkg::S_MAP_RD: begin
        state_next = (scd_pkg::kind_t'(kind_q) == scd_pkg::K_ADD) ?
                     scd_pkg::S_ADD_DEC : scd_pkg::S_PC_MAP;
      end
      scd_pkg::S_ADD_DEC: begin
        if (map_rdata == scd_pkg::MAP_EMPTY ||
            map_rdata >= scd_pkg::MAP_W'(scd_pkg::PATCH_SLOTS)) begin
          if (pcount >= scd_pkg::PCOUNT_W'(scd_pkg::PATCH_SLOTS)) begin
            emit_req      = 1'b1;
            emit_val.code = scd_pkg::RES_FULL;
            if (emit_ok) begin
              state_next = scd_pkg::S_FIN;
            end
          end else begin
            map_we     = 1'b1;
            patch_we   = 1'b1;
            pcount_inc = 1'b1;
            state_next = scd_pkg::S_FIN;
          end
        end else begin
          patch_we    = 1'b1;
          patch_waddr = map_rdata[scd_pkg::PATCH_W-1:0];
          state_next  = scd_pkg::S_FIN;
        end
      end
      scd_pkg::S_PC_MAP: begin
        if (map_rdata != scd_pkg::MAP_EMPTY &&
            map_rdata < scd_pkg::MAP_W'(scd_pkg::PATCH_SLOTS)) begin
          patch_raddr = map_rdata[scd_pkg::PATCH_W-1:0];
          pidx_next   = map_rdata[scd_pkg::PATCH_W-1:0];
          state_next  = scd_pkg::S_PC_HOOK;
        end else begin
          state_next = scd_pkg::S_FIN;
        end
      end
      scd_pkg::S_PC_HOOK: begin
        emit_req      = patch_rdata.hooks[0] || rec;
        emit_val.code = patch_rdata.hooks[0] ? scd_pkg::RES_HEAD : scd_pkg::RES_NONE;
        emit_val.idx  = pidx;
        emit_val.num  = patch_rdata.number;
        emit_val.slot = rec ? pend_cnt[scd_pkg::SLOT_W-1:0] : '0;
        if (!emit_req || emit_ok) begin
          pend_we    = rec;
          pend_inc   = rec;
          state_next = drop ? scd_pkg::S_PC_DROP : scd_pkg::S_FIN;
        end
      end
      scd_pkg::S_PC_DROP: begin
        emit_req      = 1'b1;
        emit_val.code = scd_pkg::RES_DROP;
        emit_val.idx  = pidx;
        emit_val.num  = patch_rdata.number;
        if (emit_ok) begin
          state_next = scd_pkg::S_FIN;
        end
      end
      scd_pkg::S_SCAN: begin
        state_next = (ptr >= pend_cnt) ? scd_pkg::S_FIN : scd_pkg::S_CMP;
      end
      scd_pkg::S_CMP: begin
        if (pend_rdata.ret == pc_q && pend_rdata.stack == sp_q) begin
          patch_raddr = pend_rdata.patch;
          pidx_next   = pend_rdata.patch;
          state_next  = scd_pkg::S_RM;
        end else begin
          ptr_inc    = 1'b1;
          state_next = scd_pkg::S_SCAN;
        end
      end
      scd_pkg::S_RM: begin
        pend_raddr    = last_slot;
        emit_req      = patch_rdata.hooks[1];
        emit_val.code = scd_pkg::RES_TAIL;
        emit_val.idx  = pidx;
        emit_val.num  = patch_rdata.number;
        emit_val.slot = ptr[scd_pkg::SLOT_W-1:0];
        if (!emit_req || emit_ok) begin
          state_next = scd_pkg::S_MOVE;
        end
      end
      scd_pkg::S_MOVE: begin
        pend_we    = ptr[scd_pkg::SLOT_W-1:0] != last_slot;
        pend_waddr = ptr[scd_pkg::SLOT_W-1:0];
        pend_wdata = pend_rdata;
        pend_dec   = 1'b1;
        state_next = scd_pkg::S_SCAN;
      end
      scd_pkg::S_FIN: begin
        if (out_free) begin
          fin_go     = 1'b1;
          state_next = scd_pkg::S_IDLE;
        end
      end
      default: state_next = scd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      tsel      <= '0;
      cdown     <= '0;
      pcount    <= '0;
      pend_cnt  <= '0;
      hvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == scd_pkg::S_CLEAR) begin
        clr <= clr + scd_pkg::KEY_W'(1);
      end
      if (accept && scd_pkg::kind_t'(kind) == scd_pkg::K_LDR) begin
        tsel  <= arm_ok ? negoff[3:0] : 4'd0;
        cdown <= arm_ok ? 2'd2 : 2'd0;
      end else if (accept && scd_pkg::kind_t'(kind) == scd_pkg::K_EXEC && cdown != 2'd0) begin
        cdown <= cdown - 2'd1;
      end
      if (pcount_inc) begin
        pcount <= pcount + scd_pkg::PCOUNT_W'(1);
      end
      if (pend_inc) begin
        pend_cnt <= pend_cnt + scd_pkg::PCNT_W'(1);
      end else if (pend_dec) begin
        pend_cnt <= pend_cnt - scd_pkg::PCNT_W'(1);
      end
      if (emit_go) begin
        hvalid <= 1'b1;
      end else if (fin_go) begin
        hvalid <= 1'b0;
      end
      if ((emit_go && hvalid) || fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      sys_q  <= syscall_number;
      head_q <= has_head;
      tail_q <= has_tail;
      sp_q   <= stack_pointer;
      lr_q   <= link_register;
      pc_q   <= program_counter;
      mkey   <= mkey_next;
      ptr    <= '0;
    end else if (ptr_inc) begin
      ptr <= ptr + scd_pkg::PCNT_W'(1);
    end
    pidx <= pidx_next;
    if (emit_go) begin
      held <= emit_val;
    end
    if (emit_go && hvalid) begin
      event_res    <= held.code;
      patch_index  <= held.idx;
      syscall_id   <= held.num;
      pending_slot <= held.slot;
      last         <= 1'b0;
    end else if (fin_go) begin
      event_res    <= hvalid ? held.code : scd_pkg::RES_NONE;
      patch_index  <= hvalid ? held.idx : '0;
      syscall_id   <= hvalid ? held.num : '0;
      pending_slot <= hvalid ? held.slot : '0;
      last         <= 1'b1;
    end
  end

  scd_ram #(.WIDTH(scd_pkg::MAP_W), .DEPTH(scd_pkg::MAP_ENTRIES)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(mkey), .rdata(map_rdata)
  );

  scd_ram #(.WIDTH($bits(scd_pkg::patch_t)), .DEPTH(scd_pkg::PATCH_SLOTS)) u_patch (
    .clk(clk), .we(patch_we), .waddr(patch_waddr), .wdata(patch_wdata),
    .raddr(patch_raddr), .rdata(patch_rdata)
  );

  scd_ram #(.WIDTH($bits(scd_pkg::pend_t)), .DEPTH(scd_pkg::PENDING_SLOTS)) u_pend (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

endmodule
`default_nettype wire

[src/scd_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/scd_checker.sv]
// Port-level checks of the trap dispatcher, bound to the top level.
// Depends on syscall_trap_dispatcher_top.
`timescale 1ns / 1ps
`default_nettype none
module scd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_res,
  input wire logic [5:0]  patch_index,
  input wire logic [31:0] syscall_id,
  input wire logic [4:0]  pending_slot,
  input wire logic        last
);

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in work");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= 3'd4)
    else $error("result code out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(syscall_id)
      && $stable(patch_index) && $stable(pending_slot) && $stable(last))
    else $error("stalled result changed");

endmodule

bind syscall_trap_dispatcher_top scd_checker u_scd_checker (.*);
`default_nettype wire

[sim/syscall_trap_dispatcher_top_test.sv]
// Testbench for the system-call trap dispatcher: directed and random request streams,
// with results predicted in-bench and checked field by field as they come out.
// Depends on scd_pkg and syscall_trap_dispatcher_top.
`timescale 1ns / 1ps
module syscall_trap_dispatcher_top_test;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    scd_pkg::res_code_t code;
    logic [5:0]  idx;
    logic [31:0] num;
    logic [4:0]  slot;
    logic        fin;
  } hook_event_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] kind = 0;
  logic signed [12:0] offset = 0;
  logic [31:0] syscall_number = 0;
  logic has_head = 0;
  logic has_tail = 0;
  logic [31:0] stack_pointer = 0;
  logic [31:0] link_register = 0;
  logic [31:0] program_counter = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] event_res;
  logic [5:0] patch_index;
  logic [31:0] syscall_id;
  logic [4:0] pending_slot;
  logic last;

  syscall_trap_dispatcher_top uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // dispatcher state as predicted
  logic [3:0]  tbl_sel;
  logic [1:0]  cdown;
  logic [6:0]  key_slot [scd_pkg::MAP_ENTRIES];
  logic [31:0] patch_num [scd_pkg::PATCH_SLOTS];
  logic [1:0]  patch_hk [scd_pkg::PATCH_SLOTS];
  int          patch_cnt;
  logic [31:0] pend_ret [scd_pkg::PENDING_SLOTS];
  logic [31:0] pend_sp [scd_pkg::PENDING_SLOTS];
  logic [5:0]  pend_idx [scd_pkg::PENDING_SLOTS];
  int          pend_cnt;

  hook_event_t expected_events[$];
  logic [31:0] known_syscalls[$];
  int errors = 0;
  int requests = 0;
  int results = 0;
  int tails_fired = 0;
  int drops = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit no_gap = 0;

  task automatic model_dispatch(input logic [1:0] k, input logic signed [12:0] off,
                                input logic [31:0] sys, input logic hh, input logic ht,
                                input logic [31:0] sp, input logic [31:0] lr,
                                input logic [31:0] pc);
    hook_event_t evs[$];
    hook_event_t e;
    logic [31:0] key;
    logic [6:0] idx;
    logic [1:0] t;
    int neg;
    int i;
    int slot;
    bit rec;
    bit drp;
    case (k)
      scd_pkg::K_ADD: begin
        key = (((sys >> 14) - 32'd1) << 10) | ((sys & 32'hfff) >> 2);
        if (key < scd_pkg::MAP_ENTRIES) begin
          idx = key_slot[key];
          if (idx == scd_pkg::MAP_EMPTY && patch_cnt >= scd_pkg::PATCH_SLOTS) begin
            evs.push_back('{scd_pkg::RES_FULL, 0, 0, 0, 0});
          end else begin
            if (idx == scd_pkg::MAP_EMPTY) begin
              idx = patch_cnt[6:0];
              patch_cnt++;
              key_slot[key] = idx;
            end
            patch_num[idx] = sys;
            patch_hk[idx] = {ht, hh};
          end
        end
      end
      scd_pkg::K_LDR: begin
        tbl_sel = 0;
        cdown = 0;
        neg = -int'(off);
        if (off < 0 && neg % 4 == 0 && neg <= 12) begin
          tbl_sel = neg[3:0];
          cdown = 2;
        end
      end
      scd_pkg::K_LDPC: begin
        t = tbl_sel[3:2];
        if (cdown == 1 && off >= 0 && off[1:0] == 0 && t != 0) begin
          key = ((32'(t) - 1) << 10) | 32'(off >>> 2);
          idx = key_slot[key];
          if (idx != scd_pkg::MAP_EMPTY) begin
            rec = 0;
            drp = 0;
            slot = 0;
            if (patch_hk[idx][1]) begin
              if (pend_cnt >= scd_pkg::PENDING_SLOTS) begin
                drp = 1;
              end else begin
                slot = pend_cnt;
                pend_cnt++;
                pend_ret[slot] = lr & ~32'd1;
                pend_sp[slot] = sp;
                pend_idx[slot] = idx[5:0];
                rec = 1;
              end
            end
            if (patch_hk[idx][0])
              evs.push_back('{scd_pkg::RES_HEAD, idx[5:0], patch_num[idx], slot[4:0], 0});
            else if (rec)
              evs.push_back('{scd_pkg::RES_NONE, idx[5:0], patch_num[idx], slot[4:0], 0});
            if (drp) begin
              evs.push_back('{scd_pkg::RES_DROP, idx[5:0], patch_num[idx], 0, 0});
              drops++;
            end
          end
        end
      end
      default: begin
        if (cdown != 0) cdown--;
        i = 0;
        while (i < pend_cnt) begin
          if (pend_ret[i] != pc || pend_sp[i] != sp) begin
            i++;
          end else begin
            if (patch_hk[pend_idx[i]][1] && evs.size() < scd_pkg::PENDING_SLOTS) begin
              evs.push_back('{scd_pkg::RES_TAIL, pend_idx[i], patch_num[pend_idx[i]],
                              i[4:0], 0});
              tails_fired++;
            end
            pend_ret[i] = pend_ret[pend_cnt-1];
            pend_sp[i] = pend_sp[pend_cnt-1];
            pend_idx[i] = pend_idx[pend_cnt-1];
            pend_cnt--;
          end
        end
      end
    endcase
    if (evs.size() == 0) evs.push_back('{scd_pkg::RES_NONE, 0, 0, 0, 0});
    evs[evs.size()-1].fin = 1;
    foreach (evs[j]) expected_events.push_back(evs[j]);
  endtask

  task automatic issue_request(input logic [1:0] k, input logic signed [12:0] off,
                               input logic [31:0] sys, input logic hh, input logic ht,
                               input logic [31:0] sp, input logic [31:0] lr,
                               input logic [31:0] pc);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    in_valid = 1;
    kind = k;
    offset = off;
    syscall_number = sys;
    has_head = hh;
    has_tail = ht;
    stack_pointer = sp;
    link_register = lr;
    program_counter = pc;
    do @(posedge clk); while (!in_ready);
    model_dispatch(k, off, sys, hh, ht, sp, lr, pc);
    requests++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic add_patch(input logic [31:0] sys, input logic hh, input logic ht);
    issue_request(scd_pkg::K_ADD, 0, sys, hh, ht, $urandom, $urandom, $urandom);
    known_syscalls.push_back(sys);
  endtask

  // arm, step once, then load pc through the table
  task automatic call_syscall(input logic [31:0] sys, input logic [31:0] sp,
                              input logic [31:0] lr);
    issue_request(scd_pkg::K_LDR, -13'(4 * int'(sys[15:14])), $urandom, 0, 0, sp,
                  $urandom, $urandom);
    issue_request(scd_pkg::K_EXEC, $urandom, $urandom, 0, 0, sp, $urandom, $urandom);
    issue_request(scd_pkg::K_LDPC, 13'(sys & 32'hffc), $urandom, 0, 0, sp, lr, $urandom);
  endtask

  task automatic return_to(input logic [31:0] pc, input logic [31:0] sp);
    issue_request(scd_pkg::K_EXEC, $urandom, $urandom, 0, 0, sp, $urandom, pc);
  endtask

  function automatic logic [31:0] random_syscall();
    return {16'd0, 2'($urandom_range(1, 3)), 14'($urandom)};
  endfunction

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results++;
      if (expected_events.size() == 0) begin
        $error("unexpected result event_res=%0d", event_res);
        errors++;
      end else begin
        if (event_res != expected_events[0].code) begin
          $error("event_res expected %0d actual %0d", expected_events[0].code, event_res);
          errors++;
        end
        if (patch_index != expected_events[0].idx) begin
          $error("patch_index expected %0d actual %0d", expected_events[0].idx, patch_index);
          errors++;
        end
        if (syscall_id != expected_events[0].num) begin
          $error("syscall_id expected %h actual %h", expected_events[0].num, syscall_id);
          errors++;
        end
        if (pending_slot != expected_events[0].slot) begin
          $error("pending_slot expected %0d actual %0d", expected_events[0].slot,
                 pending_slot);
          errors++;
        end
        if (last != expected_events[0].fin) begin
          $error("last expected %0d actual %0d", expected_events[0].fin, last);
          errors++;
        end
        void'(expected_events.pop_front());
      end
    end
  end

  initial begin
    int stall;
    forever begin
      stall = no_gap ? 0 : $urandom_range(0, 10);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_arming_and_quiet();
    logic signed [12:0] offs [9] = '{0, -4, -8, -12, -16, -6, 4095, -4095, 4};
    foreach (offs[i]) issue_request(scd_pkg::K_LDR, offs[i], 0, 0, 0, 0, 0, 0);
    issue_request(scd_pkg::K_LDPC, 0, 0, 0, 0, 0, 0, 0);
    issue_request(scd_pkg::K_EXEC, -1, '1, 1, 1, '1, '1, '1);
  endtask

  task automatic test_add_and_head();
    add_patch(32'h0000_4004, 1, 0);
    add_patch(32'h0000_8ffc, 0, 1);
    add_patch(32'h0000_c800, 1, 1);
    add_patch(32'h0000_4010, 0, 0);
    issue_request(scd_pkg::K_ADD, 0, 32'h0000_0ffc, 1, 1, 0, 0, 0);
    issue_request(scd_pkg::K_ADD, 0, 32'hffff_ffff, 1, 1, 0, 0, 0);
    call_syscall(32'h0000_4004, 32'h100, 32'h2001);
    call_syscall(32'h0000_4010, 32'h100, 32'h2001);
    issue_request(scd_pkg::K_LDR, -8, 0, 0, 0, 0, 0, 0);
    issue_request(scd_pkg::K_LDPC, 13'h7fc, 0, 0, 0, 0, 0, 0);
    add_patch(32'h0000_4004, 1, 1);
  endtask

  task automatic test_tail_removal();
    call_syscall(32'h0000_8ffc, 32'h200, 32'h3001);
    call_syscall(32'h0000_c800, 32'h200, 32'h3000);
    call_syscall(32'h0000_4004, 32'h300, 32'h3000);
    call_syscall(32'h0000_8ffc, 32'h200, 32'h3000);
    add_patch(32'h0000_c800, 1, 0);
    return_to(32'h3000, 32'h200);
    return_to(32'h3000, 32'h300);
  endtask

  task automatic test_pending_full();
    for (int i = 0; i < scd_pkg::PENDING_SLOTS / 2; i++)
      call_syscall(32'h0000_c800 ^ (i % 2 ? 32'h0 : 32'h4004 ^ 32'hc800), 32'h400, 32'h5000);
    add_patch(32'h0000_c800, 1, 1);
    for (int i = 0; i < scd_pkg::PENDING_SLOTS / 2 + 10; i++)
      call_syscall(32'h0000_c800, 32'h400, 32'h5000);
    return_to(32'h5000, 32'h400);
  endtask

  task automatic test_random_stream();
    logic [31:0] sys;
    for (int n = 0; n < 60; n++) begin
      no_gap = (n >= 20 && n < 36);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          call_syscall(known_syscalls[$urandom_range(0, known_syscalls.size() - 1)],
                       32'h600 + 4 * $urandom_range(0, 3), $urandom);
        5: begin
          sys = $urandom_range(0, 3) == 0 ?
                known_syscalls[$urandom_range(0, known_syscalls.size() - 1)] : random_syscall();
          add_patch(sys, $urandom, $urandom);
        end
        6, 7:
          if (pend_cnt > 0) begin
            stall_pick: begin
              int p;
              p = $urandom_range(0, pend_cnt - 1);
              return_to(pend_ret[p], pend_sp[p]);
            end
          end else begin
            return_to($urandom, $urandom);
          end
        8: issue_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
        default: return_to($urandom, 32'h600 + 4 * $urandom_range(0, 3));
      endcase
    end
    no_gap = 0;
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 300;
    @(negedge clk);
    for (int i = 0; i < 12; i++)
      call_syscall(known_syscalls[$urandom_range(0, known_syscalls.size() - 1)],
                   32'h700, $urandom);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < scd_pkg::PATCH_SLOTS + 2; i++)
      add_patch({16'd0, 2'(1 + i % 3), 2'd0, 10'(i * 7 + 3), 2'd0}, $urandom, $urandom);
  endtask

  initial begin
    tbl_sel = 0;
    cdown = 0;
    patch_cnt = 0;
    pend_cnt = 0;
    foreach (key_slot[i]) key_slot[i] = scd_pkg::MAP_EMPTY;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_arming_and_quiet();
    test_add_and_head();
    test_tail_removal();
    test_pending_full();
    test_random_stream();
    test_output_backpressure();
    test_store_full();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests and %0d results: %0d tail hooks fired, %0d tails dropped,",
             requests, results, tails_fired, drops);
    $display("patch store filled to %0d slots, pending table peaked under back-pressure",
             patch_cnt);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[files.f]
src/scd_pkg.sv
src/scd_ram.sv
src/syscall_trap_dispatcher_top.sv
src/scd_checker.sv
sim/syscall_trap_dispatcher_top_test.sv
